### design/pow2_size_class_allocator_core_assert.svh
// assertion macros shared by the checker
`ifndef POW2_SIZE_CLASS_ALLOCATOR_CORE_ASSERT_SVH
`define POW2_SIZE_CLASS_ALLOCATOR_CORE_ASSERT_SVH

// implication checked at every rising edge outside reset
`define PSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// implication whose consequent is checked in the next cycle
`define PSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### design/psa_pkg.sv
package psa_pkg;
    localparam int MIN_CLASS_LG = 7;
    localparam int MAX_CLASS_LG = 31;
    localparam int GROW_LOG2    = 26;
    localparam int STACK_DEPTH  = 64;
    localparam int NUM_CLASSES  = MAX_CLASS_LG - MIN_CLASS_LG + 1;
    localparam int SPLIT_REACH  = 3;
    localparam int ADDR_BITS    = 32;
    localparam int CLS_W        = $clog2(NUM_CLASSES);
    localparam int SP_W         = $clog2(STACK_DEPTH);
    localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
    localparam int MEM_AW       = $clog2(NUM_CLASSES * STACK_DEPTH);
    localparam int LOG_W        = 6;
    localparam int GLOG_C       = (GROW_LOG2 < MIN_CLASS_LG) ? MIN_CLASS_LG :
                                  ((GROW_LOG2 > MAX_CLASS_LG) ? MAX_CLASS_LG : GROW_LOG2);
    localparam int GCLS         = GLOG_C - MIN_CLASS_LG;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_BIG  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [2:0] REG_POOL_BASE  = 3'd0;
    localparam logic [2:0] REG_POOL_LIMIT = 3'd4;

    localparam logic [1:0] PUSH_OP = 2'd1;
    localparam logic [1:0] POP_OP  = 2'd2;
    localparam logic [1:0] NO_OP   = 2'd0;

    typedef struct packed {
        logic [1:0]       op;
        logic [CLS_W-1:0] cls;
        logic [31:0]      data;
    } t_stk_req;

    typedef struct packed {
        logic        ok;
        logic        done;
        logic [31:0] data;
    } t_stk_rsp;
endpackage

### design/psa_if.sv
interface psa_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] size_bytes;
    logic [31:0] address;
    modport source (output valid, cmd, size_bytes, address, input ready);
    modport sink (input valid, cmd, size_bytes, address, output ready);
endinterface

interface psa_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] block_address;
    logic [31:0] granted_size;
    logic [1:0]  status;
    modport source (output valid, block_address, granted_size, status, input ready);
    modport sink (input valid, block_address, granted_size, status, output ready);
endinterface

### design/psa_stacks.sv
module psa_stacks
    import psa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_stk_req i_req,
    output t_stk_rsp o_rsp
);
    logic [31:0]      r_mem [NUM_CLASSES*STACK_DEPTH];
    logic [CNT_W-1:0] r_cnt [NUM_CLASSES];
    logic [31:0]      r_rd;
    logic             r_ok;
    logic             r_done;
    logic [CNT_W-1:0] cnt;
    logic [MEM_AW-1:0] wa;
    logic [MEM_AW-1:0] ra;

    assign cnt = r_cnt[i_req.cls];
    assign wa  = MEM_AW'(i_req.cls) * MEM_AW'(STACK_DEPTH) + MEM_AW'(cnt[SP_W-1:0]);
    assign ra  = MEM_AW'(i_req.cls) * MEM_AW'(STACK_DEPTH) + MEM_AW'(cnt - CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_req.op == PUSH_OP && cnt < CNT_W'(STACK_DEPTH)) begin
            r_mem[wa] <= i_req.data;
        end
        r_rd <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CLASSES; k++) r_cnt[k] <= '0;
            r_ok   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_req.op != NO_OP;
            r_ok   <= 1'b0;
            case (i_req.op)
                PUSH_OP: begin
                    if (cnt < CNT_W'(STACK_DEPTH)) begin
                        r_cnt[i_req.cls] <= cnt + CNT_W'(1);
                        r_ok <= 1'b1;
                    end
                end
                POP_OP: begin
                    if (cnt != '0) begin
                        r_cnt[i_req.cls] <= cnt - CNT_W'(1);
                        r_ok <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_rsp.ok   = r_ok;
    assign o_rsp.done = r_done;
    assign o_rsp.data = r_rd;
endmodule

### design/pow2_size_class_allocator_core.sv
// channel | dir | handshake      | payload
// req     | in  | valid/ready    | cmd, size_bytes, address
// rsp     | out | valid/ready    | block_address, granted_size, status
// cfg     | in  | apb write/read | pool_base (0x0), pool_limit (0x4)
// one item at a time: a free pushes its block and waits for the stack reply; an
// alloc pops (S_POP, S_WAIT) its class and then higher ones up to the bound,
// else bumps the pool (S_GROW), pushes each split half (S_SPLIT, S_PWAIT) and
// ends in S_SPLIT; the stack memory's single access per cycle sets the pace
// synchronous active-low reset clears counts, state, pool base, limit and bump
// ready is low from acceptance until the result transfer completes
module pow2_size_class_allocator_core
    import psa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    psa_req_if.sink     i_req,
    psa_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POP   = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_SPLIT = 3'd3;
    localparam logic [2:0] S_PWAIT = 3'd4;
    localparam logic [2:0] S_GROW  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;
    localparam logic [2:0] S_FREEW = 3'd7;

    logic [2:0]       r_state;
    logic [31:0]      r_base, r_limit, r_bump;
    logic [LOG_W-1:0] r_lg;
    logic [CLS_W-1:0] r_cls;   // requested class
    logic [CLS_W-1:0] r_cur;   // class being searched or split
    logic [CLS_W-1:0] r_end;
    logic [31:0]      r_blk;
    logic [1:0]       r_st;
    logic [31:0]      r_oaddr, r_osize;
    t_stk_req         stk_req;
    t_stk_rsp         stk_rsp;

    // size rounding: log2 ceiling through a priority search of size-1
    logic [31:0]      sm1;
    logic [LOG_W-1:0] lg_raw, lg_c;
    logic             big;
    always_comb begin
        sm1 = i_req.size_bytes - 32'd1;
        lg_raw = '0;
        for (int k = 0; k < 32; k++) begin
            if (sm1[k]) lg_raw = LOG_W'(k + 1);
        end
        if (i_req.size_bytes == 32'd0) lg_raw = '0;
        lg_c = (lg_raw < LOG_W'(MIN_CLASS_LG)) ? LOG_W'(MIN_CLASS_LG) : lg_raw;
        big  = lg_raw > LOG_W'(MAX_CLASS_LG);
    end

    // split search bound and grow chunk
    logic [CLS_W:0]   end_raw;
    logic [LOG_W-1:0] clog;
    logic [32:0]      bump_sum;
    assign end_raw  = (CLS_W+1)'(r_cls) + (CLS_W+1)'(SPLIT_REACH);
    assign clog     = (r_lg > LOG_W'(GLOG_C)) ? r_lg : LOG_W'(GLOG_C);
    assign bump_sum = {1'b0, r_bump} + (33'd1 << clog);

    // the half pushed when splitting a block of class r_cur
    logic [31:0] half;
    assign half = 32'd1 << (LOG_W'(r_cur) + LOG_W'(MIN_CLASS_LG) - LOG_W'(1));

    psa_stacks u_stacks (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (stk_req),
        .o_rsp  (stk_rsp)
    );

    logic acc, cfg_wr;
    assign acc    = i_req.valid && i_req.ready;
    assign cfg_wr = psel && penable && pwrite;
    assign i_req.ready = (r_state == S_IDLE) && !o_rsp.valid;
    assign pready = 1'b1;
    assign prdata = (paddr == REG_POOL_LIMIT) ? r_limit : r_base;

    logic r_ovalid;
    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.block_address = r_oaddr;
    assign o_rsp.granted_size  = r_osize;
    assign o_rsp.status        = r_st;

    always_comb begin
        stk_req = '{op: NO_OP, cls: r_cur, data: '0};
        case (r_state)
            S_IDLE: begin
                if (acc && !big && i_req.cmd == CMD_FREE) begin
                    stk_req = '{op: PUSH_OP, cls: CLS_W'(lg_c - LOG_W'(MIN_CLASS_LG)),
                                data: i_req.address};
                end
            end
            S_POP: stk_req.op = POP_OP;
            S_SPLIT: begin
                if (r_cur > r_cls) begin
                    stk_req = '{op: PUSH_OP, cls: r_cur - CLS_W'(1), data: r_blk + half};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_base   <= '0;
            r_limit  <= '0;
            r_bump   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (cfg_wr && paddr == REG_POOL_BASE) begin
                r_base <= pwdata;
                r_bump <= pwdata;
            end
            if (cfg_wr && paddr == REG_POOL_LIMIT) r_limit <= pwdata;
            if (o_rsp.valid && o_rsp.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_lg  <= lg_c;
                        r_cls <= CLS_W'(lg_c - LOG_W'(MIN_CLASS_LG));
                        r_cur <= CLS_W'(lg_c - LOG_W'(MIN_CLASS_LG));
                        r_st  <= big ? ST_BIG : ST_OK;
                        if (big) begin
                            r_oaddr <= '0; r_osize <= '0;
                            r_ovalid <= 1'b1;
                        end else if (i_req.cmd == CMD_FREE) begin
                            r_oaddr <= i_req.address;
                            r_osize <= 32'd1 << lg_c;
                            r_state <= S_FREEW;
                        end else begin
                            r_state <= S_POP;
                        end
                    end
                end
                S_FREEW: begin
                    if (stk_rsp.done) begin
                        if (!stk_rsp.ok) r_st <= ST_FULL;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_POP: r_state <= S_WAIT;
                S_WAIT: begin
                    if (stk_rsp.ok) begin
                        r_blk <= stk_rsp.data;
                        r_state <= S_SPLIT;
                    end else begin
                        if (r_cur == r_cls) begin
                            // bound of the search: max(class+3, grow class), capped
                            if (end_raw < (CLS_W+1)'(GCLS)) r_end <= CLS_W'(GCLS);
                            else if (end_raw > (CLS_W+1)'(NUM_CLASSES-1))
                                r_end <= CLS_W'(NUM_CLASSES-1);
                            else r_end <= end_raw[CLS_W-1:0];
                        end
                        if (r_cur == r_cls && r_cls != CLS_W'(NUM_CLASSES-1)) begin
                            r_cur <= r_cur + CLS_W'(1); r_state <= S_POP;
                        end else if (r_cur != r_cls && r_cur < r_end) begin
                            r_cur <= r_cur + CLS_W'(1); r_state <= S_POP;
                        end else begin
                            r_state <= S_GROW;
                        end
                    end
                end
                S_GROW: begin
                    if (bump_sum > {1'b0, r_limit}) begin
                        r_st <= ST_OOM; r_oaddr <= '0; r_osize <= '0;
                        r_ovalid <= 1'b1; r_state <= S_IDLE;
                    end else begin
                        r_blk  <= r_bump;
                        r_bump <= bump_sum[31:0];
                        r_cur  <= CLS_W'(clog - LOG_W'(MIN_CLASS_LG));
                        r_state <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    if (r_cur > r_cls) begin
                        r_cur <= r_cur - CLS_W'(1);
                        r_state <= S_PWAIT;
                    end else begin
                        r_oaddr <= r_blk;
                        r_osize <= 32'd1 << r_lg;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_PWAIT: begin
                    if (!stk_rsp.ok) r_st <= ST_FULL;
                    r_state <= S_SPLIT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### design/psa_checker.sv
`include "pow2_size_class_allocator_core_assert.svh"
module psa_checker
    import psa_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] rsp_addr,
    input logic [31:0] rsp_size,
    input logic [1:0]  rsp_status
);
    // no new transfer while a result is pending
    `PSA_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, rsp_valid, !req_ready)
    // out-of-memory and oversized results report zero size
    `PSA_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n,
        rsp_valid && (rsp_status == ST_OOM || rsp_status == ST_BIG), rsp_size == 32'd0)
    // a stalled result holds
    `PSA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_addr) && $stable(rsp_status))
    // accepting an item drops ready
    `PSA_ASSERT_NEXT(a_busy, i_clk, i_rst_n, req_valid && req_ready, !req_ready)
endmodule

bind pow2_size_class_allocator_core psa_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(i_req.valid), .req_ready(i_req.ready),
    .rsp_valid(o_rsp.valid), .rsp_ready(o_rsp.ready),
    .rsp_addr(o_rsp.block_address), .rsp_size(o_rsp.granted_size),
    .rsp_status(o_rsp.status)
);

### tb/pow2_size_class_allocator_core_test.sv
module pow2_size_class_allocator_core_test
    import psa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 120;
    localparam int RANDOM_ITEMS = 930;

    typedef struct {
        logic [31:0] blk;
        logic [31:0] size;
        logic [1:0]  status;
    } t_grant;

    typedef struct {
        logic        cmd;
        logic [31:0] size;
        logic [31:0] addr;
        bit          typed;
        logic [31:0] exp_blk;
        logic [31:0] exp_size;
        logic [1:0]  exp_status;
    } t_stim_row;

    typedef struct {
        logic [31:0] addr;
        logic [31:0] size;
    } t_live_block;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    psa_req_if req_ch();
    psa_rsp_if rsp_ch();

    pow2_size_class_allocator_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // own copy of the allocator state
    logic [31:0] free_list [NUM_CLASSES][STACK_DEPTH];
    int          free_count [NUM_CLASSES];
    logic [31:0] bump_ptr;
    logic [31:0] region_base;
    logic [31:0] region_limit;

    t_grant      expected_grants[$];
    t_live_block live_blocks[$];

    int err_count;
    int cycle_count;
    int sent_count;
    int grant_count;
    int oom_count;
    int big_count;
    int full_count;
    int snd_idle_pct;
    int rcv_stall_pct;

    always #4 i_clk = ~i_clk;

    // give up if the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // result check on every transfer, oldest expectation first
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_grants.size() == 0) begin
                $error("unexpected result: block_address %h granted_size %h status %0d",
                       rsp_ch.block_address, rsp_ch.granted_size, rsp_ch.status);
                err_count++;
            end else begin
                want = expected_grants.pop_front();
                if (rsp_ch.block_address !== want.blk) begin
                    $error("block_address: expected %h, got %h", want.blk, rsp_ch.block_address);
                    err_count++;
                end
                if (rsp_ch.granted_size !== want.size) begin
                    $error("granted_size: expected %h, got %h", want.size, rsp_ch.granted_size);
                    err_count++;
                end
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    err_count++;
                end
            end
        end
    end

    function automatic bit push_free(int cls, logic [31:0] addr);
        if (cls < 0 || cls >= NUM_CLASSES) return 1'b0;
        if (free_count[cls] >= STACK_DEPTH) return 1'b0;
        free_list[cls][free_count[cls]] = addr;
        free_count[cls]++;
        return 1'b1;
    endfunction

    function automatic bit pop_free(int cls, output logic [31:0] addr);
        addr = '0;
        if (cls < 0 || cls >= NUM_CLASSES || free_count[cls] == 0) return 1'b0;
        free_count[cls]--;
        addr = free_list[cls][free_count[cls]];
        return 1'b1;
    endfunction

    // buddy split: right halves go one class lower each step
    function automatic bit split_block(logic [31:0] blk, int from, int to);
        bit ok;
        logic [31:0] half;
        ok = 1'b1;
        for (int j = from; j > to; j--) begin
            half = 32'd1 << (j + MIN_CLASS_LG - 1);
            if (!push_free(j - 1, blk + half)) ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic t_grant predict_grant(logic cmd, logic [31:0] size, logic [31:0] addr);
        t_grant g;
        int lg;
        int cls;
        int last;
        int clog;
        bit found;
        logic [31:0] blk;
        logic [32:0] chunk;
        g.blk = '0;
        g.size = '0;
        g.status = ST_OK;
        found = 1'b0;
        blk = '0;
        if (size > 32'h8000_0000) begin
            g.status = ST_BIG;
            return g;
        end
        lg = 0;
        while (lg < 32 && (33'd1 << lg) < {1'b0, size}) lg++;
        if (lg < MIN_CLASS_LG) lg = MIN_CLASS_LG;
        cls = lg - MIN_CLASS_LG;
        if (cmd == CMD_FREE) begin
            if (!push_free(cls, addr)) g.status = ST_FULL;
            g.blk = addr;
            g.size = 32'd1 << lg;
            return g;
        end
        if (pop_free(cls, blk)) begin
            found = 1'b1;
        end else begin
            last = cls + SPLIT_REACH;
            if (last < GCLS) last = GCLS;
            if (last > NUM_CLASSES - 1) last = NUM_CLASSES - 1;
            for (int i = cls + 1; i <= last && !found; i++) begin
                if (pop_free(i, blk)) begin
                    found = 1'b1;
                    if (!split_block(blk, i, cls)) g.status = ST_FULL;
                end
            end
        end
        if (!found) begin
            // grow from the pool: at least one grow-sized chunk
            clog = (lg > GLOG_C) ? lg : GLOG_C;
            chunk = 33'd1 << clog;
            if ({1'b0, bump_ptr} + chunk > {1'b0, region_limit}) begin
                g.status = ST_OOM;
                return g;
            end
            blk = bump_ptr;
            bump_ptr = bump_ptr + chunk[31:0];
            if (!split_block(blk, clog - MIN_CLASS_LG, cls)) g.status = ST_FULL;
        end
        g.blk = blk;
        g.size = 32'd1 << lg;
        return g;
    endfunction

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_POOL_BASE) begin
            region_base = data;
            bump_ptr = data;
        end else begin
            region_limit = data;
        end
    endtask

    // pool registers only change once every result is back
    task automatic set_pool(logic [31:0] base, logic [31:0] limit);
        while (expected_grants.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        apb_write(REG_POOL_BASE, base);
        apb_write(REG_POOL_LIMIT, limit);
    endtask

    // one request transfer; valid stays high for a back-to-back follower
    task automatic send_request(logic cmd, logic [31:0] size, logic [31:0] addr,
                                bit typed, t_grant typed_grant);
        t_grant g;
        while ($urandom_range(99) < snd_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= cmd;
        req_ch.size_bytes <= size;
        req_ch.address    <= addr;
        do @(posedge i_clk); while (!req_ch.ready);
        g = predict_grant(cmd, size, addr);
        if (typed) g = typed_grant;
        expected_grants.push_back(g);
        sent_count++;
        case (g.status)
            ST_OOM:  oom_count++;
            ST_BIG:  big_count++;
            ST_FULL: full_count++;
            default: begin
                grant_count++;
                if (cmd == CMD_ALLOC) live_blocks.push_back('{g.blk, g.size});
            end
        endcase
    endtask

    function automatic logic [31:0] pick_size();
        int lg;
        int roll;
        logic [31:0] lo;
        roll = $urandom_range(99);
        if (roll < 3) return $urandom_range(32'hFFFF_FFFF, 32'h8000_0001);
        if (roll < 7) lg = $urandom_range(31, 20);
        else lg = $urandom_range(12, 0);
        if (lg == 0) return $urandom_range(1, 0);
        lo = (32'd1 << (lg - 1)) + 32'd1;
        return $urandom_range(32'd1 << lg, lo);
    endfunction

    task automatic random_phase(int count);
        t_grant none;
        t_live_block lb;
        int k;
        int cls_lg;
        int n;
        none = '{'0, '0, ST_OK};
        n = 0;
        while (n < count) begin
            if ($urandom_range(299) == 0) begin
                // burst of frees into one class to overrun its stack
                cls_lg = $urandom_range(10, 7);
                for (int b = 0; b < STACK_DEPTH + 6; b++)
                    send_request(CMD_FREE, 32'd1 << cls_lg, $urandom, 1'b0, none);
                n += STACK_DEPTH + 5;
            end else if ($urandom_range(99) < 55) begin
                send_request(CMD_ALLOC, pick_size(), $urandom, 1'b0, none);
            end else if (live_blocks.size() != 0 && $urandom_range(99) < 75) begin
                // well-formed free of a block granted earlier
                k = $urandom_range(live_blocks.size() - 1);
                lb = live_blocks[k];
                live_blocks.delete(k);
                send_request(CMD_FREE, lb.size, lb.addr, 1'b0, none);
            end else begin
                send_request(CMD_FREE, pick_size(), $urandom, 1'b0, none);
            end
            n++;
        end
    endtask

    t_stim_row directed_rows[15];

    initial begin
        t_grant tg;
        directed_rows = '{
            // pool empty after reset: any grow is out of memory
            '{CMD_ALLOC, 32'd1,          32'h0,         1, 32'h0,         32'h0,         ST_OOM},
            '{CMD_ALLOC, 32'hFFFF_FFFF,  32'h0,         1, 32'h0,         32'h0,         ST_BIG},
            '{CMD_FREE,  32'h8000_0001,  32'h1234,      1, 32'h0,         32'h0,         ST_BIG},
            // size zero rounds to the minimum class, address zero is legal
            '{CMD_FREE,  32'd0,          32'h0,         1, 32'h0,         32'd128,       ST_OK},
            '{CMD_ALLOC, 32'd128,        32'hFFFF_FFFF, 1, 32'h0,         32'd128,       ST_OK},
            '{CMD_FREE,  32'h8000_0000,  32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'h8000_0000, ST_OK},
            '{CMD_ALLOC, 32'h8000_0000,  32'h0,         1, 32'hFFFF_FFFF, 32'h8000_0000, ST_OK},
            '{CMD_FREE,  32'd1,          32'hA5A5_A5A5, 1, 32'hA5A5_A5A5, 32'd128,       ST_OK},
            '{CMD_FREE,  32'd200,        32'h5A5A_5A00, 1, 32'h5A5A_5A00, 32'd256,       ST_OK},
            '{CMD_ALLOC, 32'd129,        32'h0,         1, 32'h5A5A_5A00, 32'd256,       ST_OK},
            '{CMD_ALLOC, 32'd100,        32'h0,         1, 32'hA5A5_A5A5, 32'd128,       ST_OK},
            '{CMD_FREE,  32'd4096,       32'h8000,      1, 32'h8000,      32'd4096,      ST_OK},
            // split of the 4 KiB block down to the minimum class
            '{CMD_ALLOC, 32'd128,        32'h0,         0, 32'h0,         32'h0,         ST_OK},
            '{CMD_ALLOC, 32'd65,         32'h0,         0, 32'h0,         32'h0,         ST_OK},
            '{CMD_ALLOC, 32'h0400_0000,  32'h0,         1, 32'h0,         32'h0,         ST_OOM}
        };

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_ALLOC;
        req_ch.size_bytes = '0;
        req_ch.address = '0;
        rsp_ch.ready = 1'b0;
        err_count = 0;
        cycle_count = 0;
        sent_count = 0;
        grant_count = 0;
        oom_count = 0;
        big_count = 0;
        full_count = 0;
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        region_base = '0;
        region_limit = '0;
        bump_ptr = '0;
        for (int c = 0; c < NUM_CLASSES; c++) free_count[c] = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            tg = '{directed_rows[r].exp_blk, directed_rows[r].exp_size,
                   directed_rows[r].exp_status};
            send_request(directed_rows[r].cmd, directed_rows[r].size,
                         directed_rows[r].addr, directed_rows[r].typed, tg);
        end
        req_ch.valid <= 1'b0;

        // pool pinned at the top of the address space: nothing fits
        set_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        tg = '{'0, '0, ST_OOM};
        send_request(CMD_ALLOC, 32'h0200_0000, 32'h0, 1'b1, tg);
        req_ch.valid <= 1'b0;

        // sender mostly busy, receiver mostly stalled; two grow chunks
        set_pool(32'h1000_0000, 32'h1800_0000);
        snd_idle_pct = 8;
        rcv_stall_pct = 67;
        random_phase(RANDOM_ITEMS / 3);
        req_ch.valid <= 1'b0;

        // roles swapped; pool near the top, limit at the maximum
        set_pool(32'hF000_0000, 32'hFFFF_FFFF);
        snd_idle_pct = 67;
        rcv_stall_pct = 8;
        random_phase(RANDOM_ITEMS / 3);
        req_ch.valid <= 1'b0;

        // full-speed on both sides over the whole address space
        set_pool(32'h0, 32'hFFFF_FFFF);
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        random_phase(RANDOM_ITEMS / 3);
        req_ch.valid <= 1'b0;

        while (expected_grants.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests sent: %0d ok, %0d out of memory, %0d oversized, %0d stack full",
                 sent_count, grant_count, oom_count, big_count, full_count);
        $display("four pool settings, idle and stall patterns on both channels");
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/psa_pkg.sv
design/psa_if.sv
design/psa_stacks.sv
design/pow2_size_class_allocator_core.sv
design/psa_checker.sv
tb/pow2_size_class_allocator_core_test.sv
